// ----- design/ucbw_pkg.sv -----
// Shared types and constants of the universal code bit writer.
package ucbw_pkg;

   localparam int CMD_W   = 3;
   localparam int VAL_W   = 32;
   localparam int RLEN_W  = 6;
   localparam int KS_W    = 5;
   localparam int DATA_W  = 44;
   localparam int LEN_W   = 9;
   localparam int FREE_W  = 4;
   localparam int BITS_W  = 9;
   localparam int TOP_W   = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_RAW    = 3'd0,
      CMD_UNARY  = 3'd1,
      CMD_GAMMA  = 3'd2,
      CMD_DELTA  = 3'd3,
      CMD_ZETA   = 3'd4,
      CMD_NIBBLE = 3'd5,
      CMD_FLUSH  = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV,
      ST_ZSET,
      ST_EMIT,
      ST_STATUS
   } state_type;

   typedef struct packed {
      logic load;
      logic decode;
      logic div_step;
      logic zeta_set;
      logic emit;
      logic adv_seg;
      logic push_status;
   } ctrl_type;

   typedef struct packed {
      logic dec_err;
      logic dec_zeta;
      logic div_last;
      logic zeta_err;
      logic seg0_empty;
      logic seg1_empty;
      logic out_free;
   } stat_type;

   // position of the highest set bit, zero for a zero word
   function automatic logic [TOP_W-1:0] top_bit(input logic [32:0] w);
      logic [TOP_W-1:0] p;
      p = '0;
      for (int i = 0; i < 33; i++) begin
         if (w[i]) p = TOP_W'(i);
      end
      return p;
   endfunction

endpackage

// ----- design/ucbw_ifs.sv -----
// Channel interfaces: request, response and control register write.
interface ucbw_req_if import ucbw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [VAL_W-1:0]  value;
   logic [RLEN_W-1:0] raw_length;
   modport source(output valid, command, value, raw_length, input ready);
   modport sink(input valid, command, value, raw_length, output ready);
endinterface

interface ucbw_rsp_if import ucbw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [7:0]        out_byte;
   logic              byte_valid;
   logic [BITS_W-1:0] code_bits;
   logic              error;
   logic              last;
   modport source(output valid, out_byte, byte_valid, code_bits, error, last, input ready);
   modport sink(input valid, out_byte, byte_valid, code_bits, error, last, output ready);
endinterface

interface ucbw_csr_if import ucbw_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [KS_W-1:0] data;
   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

// ----- design/ucbw_ctrl.sv -----
// Sequencer of the code bit writer: decode, divide, emit and status steps.
module ucbw_ctrl import ucbw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type sts,
   output ctrl_type ctl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            ctl.decode = 1'b1;
            if (sts.dec_err) state_in = ST_STATUS;
            else if (sts.dec_zeta) state_in = ST_DIV;
            else state_in = ST_EMIT;
         end
         ST_DIV: begin
            ctl.div_step = 1'b1;
            if (sts.div_last) state_in = ST_ZSET;
         end
         ST_ZSET: begin
            ctl.zeta_set = 1'b1;
            state_in = sts.zeta_err ? ST_STATUS : ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.seg0_empty) begin
               if (sts.seg1_empty) state_in = ST_STATUS;
               else ctl.adv_seg = 1'b1;
            end else if (sts.out_free) begin
               ctl.emit = 1'b1;
            end
         end
         ST_STATUS: begin
            if (sts.out_free) begin
               ctl.push_status = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- design/ucbw_datapath.sv -----
// Code builder, quotient unit, bit packer and output word register.
module ucbw_datapath import ucbw_pkg::*; #(
   parameter int MAX_UNARY   = 255,
   parameter int VALUE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_type          ctl,
   output stat_type          sts,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [VAL_W-1:0]  req_value,
   input  logic [RLEN_W-1:0] req_raw_length,
   input  logic [KS_W-1:0]   zeta_k,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_byte_valid,
   output logic [BITS_W-1:0] rsp_code_bits,
   output logic              rsp_error,
   output logic              rsp_last
);

   localparam logic [63:0] WIDE_MASK =
      64'hFFFF_FFFF & ~((64'd1 << VALUE_WIDTH) - 64'd1);
   localparam logic [VAL_W-1:0] HIGH_MASK = WIDE_MASK[VAL_W-1:0];
   localparam logic [31:0]      UMAX      = 32'(MAX_UNARY);

   cmd_type             cmd_ff;
   logic [VAL_W-1:0]    value_ff;
   logic [RLEN_W-1:0]   rlen_ff;
   logic [32:0]         y_ff;
   logic [TOP_W-1:0]    m_ff;
   logic                err_ff;
   logic [DATA_W-1:0]   seg0_data_ff, seg1_data_ff;
   logic [LEN_W-1:0]    seg0_len_ff, seg1_len_ff;
   logic [7:0]          partial_ff;
   logic [FREE_W-1:0]   free_ff;
   logic [BITS_W-1:0]   bitcnt_ff;
   logic [4:0]          rem_ff;
   logic [TOP_W-1:0]    dvd_ff;
   logic [2:0]          div_cnt_ff;
   logic                rsp_valid_ff;
   logic [7:0]          out_byte_ff;
   logic                byte_valid_ff;
   logic [BITS_W-1:0]   code_bits_ff;
   logic                error_ff;
   logic                last_ff;

   // decode
   logic [32:0]         y_c;
   logic [TOP_W-1:0]    m_c, z_c, mm_c, tbx_c;
   logic [8:0]          prod_c;
   logic [3:0]          grp_c;
   logic [DATA_W-1:0]   nib_c;
   logic [32:0]         xv_c;
   logic                too_wide_c, dec_err_c;
   logic [KS_W-1:0]     k_c;
   logic [DATA_W-1:0]   d0_c, d1_c;
   logic [LEN_W-1:0]    l0_c, l1_c;

   assign k_c    = (zeta_k == '0) ? KS_W'(1) : zeta_k;
   assign y_c    = {1'b0, value_ff} + 33'd1;
   assign m_c    = top_bit(y_c);
   assign z_c    = m_c + TOP_W'(1);
   assign mm_c   = top_bit({27'd0, z_c});
   assign xv_c   = {1'b0, value_ff};
   assign tbx_c  = top_bit(xv_c);
   // divide by three through multiply by 11 and shift, exact for 0..31
   assign prod_c = 9'(tbx_c) * 9'd11;
   assign grp_c  = prod_c[8:5] + 4'd1;
   assign too_wide_c = (value_ff & HIGH_MASK) != '0;

   always_comb begin
      for (int i = 0; i < 11; i++) begin
         nib_c[4*i +: 4] = {(i == 0), xv_c[3*i +: 3]};
      end
   end

   always_comb begin
      dec_err_c = 1'b0;
      d0_c = '0;
      d1_c = '0;
      l0_c = '0;
      l1_c = '0;
      case (cmd_ff)
         CMD_RAW: begin
            dec_err_c = rlen_ff > RLEN_W'(32);
            d0_c = DATA_W'(value_ff);
            l0_c = LEN_W'(rlen_ff);
         end
         CMD_UNARY: begin
            dec_err_c = too_wide_c || (value_ff > UMAX);
            d0_c = DATA_W'(1);
            l0_c = value_ff[LEN_W-1:0] + LEN_W'(1);
         end
         CMD_GAMMA: begin
            dec_err_c = too_wide_c || (32'(m_c) > UMAX);
            d0_c = DATA_W'(y_c);
            l0_c = LEN_W'({m_c, 1'b0}) + LEN_W'(1);
         end
         CMD_DELTA: begin
            dec_err_c = too_wide_c || (32'(mm_c) > UMAX);
            d0_c = DATA_W'(z_c);
            l0_c = LEN_W'({mm_c, 1'b0}) + LEN_W'(1);
            d1_c = DATA_W'(y_c);
            l1_c = LEN_W'(m_c);
         end
         CMD_ZETA: begin
            dec_err_c = too_wide_c;
         end
         CMD_NIBBLE: begin
            dec_err_c = too_wide_c;
            d0_c = nib_c;
            l0_c = {3'd0, grp_c, 2'b00};
         end
         CMD_FLUSH: begin
            l0_c = (free_ff == FREE_W'(8)) ? '0 : LEN_W'(free_ff);
         end
         default: dec_err_c = 1'b1;
      endcase
   end

   // quotient unit, one bit a step
   logic [5:0] trial_c;
   logic       ge_c;
   logic [5:0] tsub_c;
   assign trial_c = {rem_ff, dvd_ff[TOP_W-1]};
   assign ge_c    = trial_c >= {1'b0, k_c};
   assign tsub_c  = trial_c - {1'b0, k_c};

   // zeta setup
   logic [10:0]       hk_c;
   logic              zeta_err_c;
   logic              same_c;
   logic [LEN_W-1:0]  zl_c;
   logic [32:0]       zd_c;
   assign hk_c       = 11'(dvd_ff) * 11'(k_c);
   assign zeta_err_c = 32'(dvd_ff) > UMAX;
   assign same_c     = hk_c == 11'(m_ff);
   assign zl_c       = same_c ? LEN_W'(hk_c) + LEN_W'(k_c) - LEN_W'(1)
                              : LEN_W'(hk_c) + LEN_W'(k_c);
   assign zd_c       = same_c ? (y_ff & ~(33'd1 << m_ff)) : y_ff;

   // packer
   logic [FREE_W-1:0] n_c, fill_c;
   logic [LEN_W-1:0]  sh_c;
   logic [DATA_W-1:0] shifted_c;
   logic [7:0]        chunk_c, new_part_c;
   logic              full_c, out_free_c;
   assign n_c       = (seg0_len_ff < LEN_W'(free_ff)) ? seg0_len_ff[FREE_W-1:0] : free_ff;
   assign sh_c      = seg0_len_ff - LEN_W'(n_c);
   assign shifted_c = (sh_c >= LEN_W'(DATA_W)) ? '0 : (seg0_data_ff >> sh_c);
   assign chunk_c   = shifted_c[7:0] & ~(8'hFF << n_c);
   assign fill_c    = free_ff - n_c;
   assign new_part_c = partial_ff | (chunk_c << fill_c);
   assign full_c    = fill_c == '0;
   assign out_free_c = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= cmd_type'(req_command);
         value_ff <= req_value;
         rlen_ff  <= req_raw_length;
      end
      if (ctl.decode) begin
         y_ff         <= y_c;
         m_ff         <= m_c;
         err_ff       <= dec_err_c;
         seg0_data_ff <= d0_c;
         seg0_len_ff  <= l0_c;
         seg1_data_ff <= d1_c;
         seg1_len_ff  <= l1_c;
         dvd_ff       <= m_c;
         rem_ff       <= '0;
      end else if (ctl.div_step) begin
         rem_ff <= ge_c ? tsub_c[4:0] : trial_c[4:0];
         dvd_ff <= {dvd_ff[TOP_W-2:0], ge_c};
      end else if (ctl.zeta_set) begin
         err_ff       <= zeta_err_c;
         seg0_data_ff <= DATA_W'(1);
         seg0_len_ff  <= LEN_W'(dvd_ff) + LEN_W'(1);
         seg1_data_ff <= DATA_W'(zd_c);
         seg1_len_ff  <= zl_c;
      end else if (ctl.adv_seg) begin
         seg0_data_ff <= seg1_data_ff;
         seg0_len_ff  <= seg1_len_ff;
         seg1_len_ff  <= '0;
      end else if (ctl.emit) begin
         seg0_len_ff <= sh_c;
      end
      if (ctl.push_status || (ctl.emit && full_c)) begin
         out_byte_ff   <= ctl.emit ? new_part_c : 8'd0;
         byte_valid_ff <= ctl.emit;
         code_bits_ff  <= (ctl.emit || err_ff) ? '0 : bitcnt_ff;
         error_ff      <= ctl.push_status && err_ff;
         last_ff       <= ctl.push_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         free_ff      <= FREE_W'(8);
         bitcnt_ff    <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.load) begin
            bitcnt_ff <= '0;
         end else if (ctl.emit) begin
            bitcnt_ff <= bitcnt_ff + BITS_W'(n_c);
         end
         if (ctl.decode) begin
            div_cnt_ff <= '0;
         end else if (ctl.div_step) begin
            div_cnt_ff <= div_cnt_ff + 3'd1;
         end
         if (ctl.emit) begin
            partial_ff <= full_c ? 8'd0 : new_part_c;
            free_ff    <= full_c ? FREE_W'(8) : fill_c;
         end
         if (ctl.push_status || (ctl.emit && full_c)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.dec_err    = dec_err_c;
      sts.dec_zeta   = cmd_ff == CMD_ZETA;
      sts.div_last   = div_cnt_ff == 3'd5;
      sts.zeta_err   = zeta_err_c;
      sts.seg0_empty = seg0_len_ff == '0;
      sts.seg1_empty = seg1_len_ff == '0;
      sts.out_free   = out_free_c;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_code_bits  = code_bits_ff;
   assign rsp_error      = error_ff;
   assign rsp_last       = last_ff;

   a_free_range: assert property (@(posedge clock) disable iff (reset)
      free_ff != '0 && free_ff <= FREE_W'(8))
      else $error("free slot count out of range");

   a_partial_clean: assert property (@(posedge clock) disable iff (reset)
      (partial_ff & ~(8'hFF << free_ff)) == 8'd0)
      else $error("bits set in empty slots of partial byte");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit || ctl.push_status) |-> out_free_c)
      else $error("output word overwritten while stalled");

   a_word_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (byte_valid_ff != last_ff))
      else $error("output word is neither byte nor status");

endmodule

// ----- design/universal_code_bit_writer_core.sv -----
// Top level of the universal code bit writer: register, sequencer and datapath.
//
// Request channel req_ch carries command, value and raw_length; each command
// appends one code (raw, unary, gamma, delta, zeta, nibble groups) or pads to a
// byte boundary. Response channel rsp_ch returns every completed byte as its
// own word (byte_valid set), then one status word (last set) with the number
// of bits appended and the error flag; rejected commands write nothing.
// csr_ch writes the zeta shrinking factor; it is always ready, reset value 3.
// One command at a time, in order: the accepting step, the decode step, for zeta
// the quotient steps and a setup step, then the emission of chunks of up to eight
// bits (a chunk ends at a byte boundary or at the end of a code field), a step
// to move to the second field of delta and zeta, a step to see the code is done
// and the status step. The packing step, moving one chunk per cycle while the
// receiver does not stall, sets the throughput.
// A single output register holds each word; while the receiver stalls, the
// packer holds, and requests stay blocked until the status enters that register.
// Reset (synchronous) empties the partial byte and drops any pending word.
module universal_code_bit_writer_core import ucbw_pkg::*; #(
   parameter int MAX_UNARY   = 255,
   parameter int VALUE_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   ucbw_req_if.sink   req_ch,
   ucbw_rsp_if.source rsp_ch,
   ucbw_csr_if.sink   csr_ch
);

   ctrl_type        ctl;
   stat_type        sts;
   logic            req_ready;
   logic [KS_W-1:0] zeta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zeta_ff <= KS_W'(3);
      end else if (csr_ch.valid) begin
         zeta_ff <= csr_ch.data;
      end
   end

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = req_ready;

   ucbw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   ucbw_datapath #(
      .MAX_UNARY   (MAX_UNARY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .sts            (sts),
      .req_command    (req_ch.command),
      .req_value      (req_ch.value),
      .req_raw_length (req_ch.raw_length),
      .zeta_k         (zeta_ff),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_out_byte   (rsp_ch.out_byte),
      .rsp_byte_valid (rsp_ch.byte_valid),
      .rsp_code_bits  (rsp_ch.code_bits),
      .rsp_error      (rsp_ch.error),
      .rsp_last       (rsp_ch.last)
   );

endmodule

// ----- dv/ucbw_checker.sv -----
// Checker for the universal code bit writer: predicts the stream and compares responses.
module ucbw_checker import ucbw_pkg::*; (
   input  logic clock,
   input  logic reset,
   ucbw_req_if.sink   req_mon,
   ucbw_rsp_if.sink   rsp_mon,
   ucbw_csr_if.sink   csr_mon,
   output int         fail_count,
   output int         pending_words,
   output int         words_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]        out_byte;
      logic              byte_valid;
      logic [BITS_W-1:0] code_bits;
      logic              error;
      logic              last;
   } rsp_word_type;

   rsp_word_type expected_words[$];
   logic [4:0]   shrink_k;
   logic [7:0]   pack_byte;
   int unsigned  open_slots;
   int unsigned  appended;

   function automatic int unsigned msb_pos(input logic [63:0] y);
      int unsigned p;
      p = 0;
      for (int i = 0; i < 64; i++) if (y[i]) p = i;
      return p;
   endfunction

   task automatic append_bit(input logic b);
      rsp_word_type w;
      open_slots--;
      pack_byte[open_slots] = b;
      appended++;
      if (open_slots == 0) begin
         w = '{out_byte: pack_byte, byte_valid: 1'b1, code_bits: '0, error: 1'b0,
               last: 1'b0};
         expected_words.push_back(w);
         pack_byte = '0;
         open_slots = 8;
      end
   endtask

   task automatic append_field(input logic [63:0] v, input int unsigned n);
      for (int i = n; i > 0; i--) append_bit(v[i-1]);
   endtask

   task automatic append_unary(input int unsigned n);
      for (int i = 0; i < n; i++) append_bit(1'b0);
      append_bit(1'b1);
   endtask

   task automatic predict_code(input logic [2:0] cmd, input logic [31:0] x,
                               input logic [5:0] rlen);
      logic [63:0]  y, z, lft;
      int unsigned  m, mm, k, h, hk, g;
      logic         bad;
      rsp_word_type st;
      y = {32'd0, x} + 64'd1;
      m = msb_pos(y);
      k = (shrink_k == 0) ? 1 : shrink_k;
      bad = 1'b0;
      appended = 0;
      case (cmd)
         CMD_RAW:   if (rlen > 32) bad = 1'b1; else append_field({32'd0, x}, rlen);
         CMD_UNARY: if (x > 255) bad = 1'b1; else append_unary(x);
         CMD_GAMMA: begin
            append_unary(m);
            append_field(y, m);
         end
         CMD_DELTA: begin
            z = m + 1;
            mm = msb_pos(z);
            append_unary(mm);
            append_field(z, mm);
            append_field(y, m);
         end
         CMD_ZETA: begin
            h = m / k;
            hk = h * k;
            lft = 64'd1 << hk;
            append_unary(h);
            if (y - lft < lft) append_field(y - lft, hk + k - 1);
            else append_field(y, hk + k);
         end
         CMD_NIBBLE: begin
            if (x == 0) append_field(64'd8, 4);
            else begin
               g = msb_pos({32'd0, x}) / 3 + 1;
               while (g > 0) begin
                  g--;
                  append_bit(g == 0);
                  append_field({32'd0, x} >> (g * 3), 3);
               end
            end
         end
         CMD_FLUSH: if (open_slots != 8) begin
            appended = open_slots;
            st = '{out_byte: pack_byte, byte_valid: 1'b1, code_bits: '0, error: 1'b0,
                   last: 1'b0};
            expected_words.push_back(st);
            pack_byte = '0;
            open_slots = 8;
         end
         default: bad = 1'b1;
      endcase
      st = '{out_byte: '0, byte_valid: 1'b0, code_bits: bad ? '0 : BITS_W'(appended),
             error: bad, last: 1'b1};
      expected_words.push_back(st);
   endtask

   always @(posedge clock) begin
      rsp_word_type got, exp_w;
      if (reset) begin
         shrink_k <= 5'd3;
         pack_byte = '0;
         open_slots = 8;
         expected_words.delete();
         fail_count <= 0;
         words_seen <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) shrink_k <= csr_mon.data;
         if (req_mon.valid && req_mon.ready)
            predict_code(req_mon.command, req_mon.value, req_mon.raw_length);
         if (rsp_mon.valid && rsp_mon.ready) begin
            words_seen <= words_seen + 1;
            got = '{out_byte: rsp_mon.out_byte, byte_valid: rsp_mon.byte_valid,
                    code_bits: rsp_mon.code_bits, error: rsp_mon.error,
                    last: rsp_mon.last};
            if (expected_words.size() == 0) begin
               $error("unexpected response word %p", got);
               fail_count <= fail_count + 1;
            end else begin
               exp_w = expected_words.pop_front();
               if (got.out_byte !== exp_w.out_byte)
                  $error("out_byte expected %0h got %0h", exp_w.out_byte, got.out_byte);
               if (got.byte_valid !== exp_w.byte_valid)
                  $error("byte_valid expected %0b got %0b", exp_w.byte_valid,
                         got.byte_valid);
               if (got.code_bits !== exp_w.code_bits)
                  $error("code_bits expected %0d got %0d", exp_w.code_bits,
                         got.code_bits);
               if (got.error !== exp_w.error)
                  $error("error expected %0b got %0b", exp_w.error, got.error);
               if (got.last !== exp_w.last)
                  $error("last expected %0b got %0b", exp_w.last, got.last);
               if (got !== exp_w) fail_count <= fail_count + 1;
            end
         end
      end
      pending_words <= expected_words.size();
   end
endmodule

// ----- dv/universal_code_bit_writer_core_test.sv -----
// Top of the universal code bit writer testbench: stimulus, idling and verdict.
module universal_code_bit_writer_core_test;
   import ucbw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CMD_UNKNOWN = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_words, words_seen;
   int   send_idle_pct = 0, stall_pct = 0, hold_off_cycles = 0;
   int   cmds_sent = 0;

   ucbw_req_if req_ch();
   ucbw_rsp_if rsp_ch();
   ucbw_csr_if csr_ch();

   universal_code_bit_writer_core u_dut(.clock(clock), .reset(reset), .req_ch(req_ch),
                                        .rsp_ch(rsp_ch), .csr_ch(csr_ch));
   ucbw_checker u_checker(.clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
                          .csr_mon(csr_ch), .fail_count(fail_count),
                          .pending_words(pending_words), .words_seen(words_seen));

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.command = '0;
      req_ch.value = '0;
      req_ch.raw_length = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
   end

   // receiver: random stall, or a long counted hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else if (hold_off_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // hold valid after acceptance; the next word or an idle cycle replaces it
   task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] v,
                           input logic [5:0] rlen);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.value <= v;
      req_ch.raw_length <= rlen;
      do @(posedge clock); while (!req_ch.ready);
      cmds_sent++;
   endtask

   task automatic drain;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_shrink(input logic [4:0] k);
      drain();
      csr_ch.valid <= 1'b1;
      csr_ch.data <= k;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic random_cmd;
      logic [2:0]  cmd;
      logic [31:0] v;
      logic [5:0]  rlen;
      cmd = 3'($urandom_range(7));
      case ($urandom_range(3))
         0: v = $urandom_range(15);
         1: v = $urandom_range(300);
         2: v = $urandom >> $urandom_range(31);
         default: v = $urandom;
      endcase
      if (cmd == CMD_UNARY && $urandom_range(3) != 0) v = $urandom_range(40);
      rlen = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(32));
      send_cmd(cmd, v, rlen);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed corners
      send_cmd(CMD_FLUSH, 32'd0, 6'd0);
      send_cmd(CMD_RAW, 32'hFFFF_FFFF, 6'd32);
      send_cmd(CMD_RAW, 32'h5, 6'd0);
      send_cmd(CMD_RAW, 32'hA5, 6'd33);
      send_cmd(CMD_RAW, 32'h1, 6'd1);
      send_cmd(CMD_UNARY, 32'd0, 6'd0);
      send_cmd(CMD_UNARY, 32'd255, 6'd0);
      send_cmd(CMD_UNARY, 32'd256, 6'd0);
      send_cmd(CMD_GAMMA, 32'd0, 6'd0);
      send_cmd(CMD_GAMMA, 32'hFFFF_FFFF, 6'd0);
      send_cmd(CMD_DELTA, 32'd0, 6'd0);
      send_cmd(CMD_DELTA, 32'hFFFF_FFFF, 6'd0);
      send_cmd(CMD_ZETA, 32'd0, 6'd0);
      send_cmd(CMD_ZETA, 32'hFFFF_FFFF, 6'd0);
      send_cmd(CMD_NIBBLE, 32'd0, 6'd0);
      send_cmd(CMD_NIBBLE, 32'hFFFF_FFFF, 6'd0);
      send_cmd(CMD_NIBBLE, 32'h8, 6'd0);
      send_cmd(CMD_FLUSH, 32'd0, 6'd0);
      send_cmd(CMD_UNKNOWN, 32'h1234, 6'd5);
      send_cmd(CMD_RAW, 32'h3, 6'd3);
      send_cmd(CMD_FLUSH, 32'd0, 6'd0);
      write_shrink(5'd0);
      send_cmd(CMD_ZETA, 32'd100, 6'd0);
      write_shrink(5'd31);
      send_cmd(CMD_ZETA, 32'hFFFF_FFFF, 6'd0);
      send_cmd(CMD_ZETA, 32'd7, 6'd0);
      // random phases under each idling mix and shrink setting
      for (int ph = 0; ph < 4; ph++) begin
         write_shrink(ph == 0 ? 5'd1 : 5'($urandom_range(1, 31)));
         send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 23 : 62) : 0;
         stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 23 : 62) : 0;
         if (ph == 2) hold_off_cycles <= 300;
         repeat (37) random_cmd();
      end
      write_shrink(5'd3);
      stall_pct = 0;
      drain();
      $display("Sent %0d commands, checked %0d response words over four idling mixes",
               cmds_sent, words_seen);
      $display("and zeta shrink factors 0, 1, 31 and random values.");
      if (fail_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
